>>> rtl/gb3_pkg.sv
// Shared types and constants for the 3x3 RGBA Gaussian blur core.
package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Dimension registers are 11 bits wide on the configuration port.
  localparam int DIM_W = 11;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PROD_W = 2 * DIM_W;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Request types.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef logic [31:0] pixel_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_of_frame;
  } out_beat_t;

endpackage

>>> rtl/gaussian_blur_3x3_rgba_core.sv
// 3x3 Gaussian blur of an RGBA8 raster stream, two row stores and a 3x3 window.
//
// Input beats carry one pixel (req_type pixel) or a drain request (req_type
// drain) that advances the raster position with a zero pixel. Pixels arrive
// in raster order; the blurred pixel for position q is released by the beat
// at input position q + width + 1, so at the end of a frame width + 1 drain
// beats flush the remaining outputs. last_of_frame marks the final pixel,
// after which the next beat starts a new frame.
// Throughput is one beat per cycle. A beat is taken in the cycle it is
// offered unless the window stage is full behind a full, stalled output
// register. The result it releases is formed in the window stage, updated
// at acceptance, then goes through the weighted sum and divide by 40 into
// the output register.
// The row stores are read ahead at the next column, so every column gets
// a fresh read without a bubble.
// Reset clears the counters and the window and sets width and height to
// 1024; the row stores are left as they are. A width or height write also
// restarts the frame. While out_stall_i holds a pending result, in_stall_o
// rises once the internal stage is occupied as well.
module gaussian_blur_3x3_rgba_core import gb3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [13:0] DIV5_MUL = 14'd13108;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic [POS_W-1:0] whm1_q;
  logic [DIM_W-1:0] w_cl, h_cl, wr_cl;
  logic             cfg_we;

  // raster state
  logic [COL_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [POS_W-1:0] pos_q, pos_d;
  pixel_t           win_q [9];

  // row stores
  pixel_t up_mem  [MAX_WIDTH];
  pixel_t mid_mem [MAX_WIDTH];
  pixel_t up_rd_q, mid_rd_q;

  // window stage and output register
  logic       s1_valid_q, s1_last_q;
  logic [8:0] mask_q;
  logic       out_valid_q;
  out_beat_t  out_q;

  logic       acc, out_free, s1_move;
  pixel_t     pix;
  logic       first_col, other_col, emit_d, last_d, wrap;
  logic [8:0] mask_d;
  logic [DIM_W-1:0] col_inc, row_inc, row_cap;
  logic [7:0] blur_ch [4];

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign w_cl   = clamp_dim(width_q, MAX_W_DIM);
  assign h_cl   = clamp_dim(height_q, MAX_H_DIM);
  assign wr_cl  = clamp_dim(pwdata[DIM_W-1:0], (paddr[2] == REG_WIDTH) ? MAX_W_DIM : MAX_H_DIM);

  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-DIM_W){1'b0}}, height_q}
                                           : {{(32-DIM_W){1'b0}}, width_q};

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    pix = '0;
    if (in_data_i.req_type == REQ_PIXEL && row_q < h_cl) begin
      pix = {in_data_i.in_alpha, in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};
    end

    first_col = (col_q == '0) && (row_q >= DIM_W'(2));
    other_col = (col_q != '0) && (row_q >= DIM_W'(1));

    mask_d = '0;
    emit_d = 1'b0;
    if (first_col) begin
      // finish the last column of the row two above: incoming column is off-image
      emit_d = row_q < h_cl + DIM_W'(2);
      mask_d[8:6] = 3'b111;
      if (w_cl == DIM_W'(1)) mask_d[2:0] = 3'b111;
      if (row_q == DIM_W'(2)) begin
        mask_d[0] = 1'b1;
        mask_d[3] = 1'b1;
      end
      if (row_q >= h_cl + DIM_W'(1)) begin
        mask_d[2] = 1'b1;
        mask_d[5] = 1'b1;
      end
    end else if (other_col) begin
      emit_d = row_q < h_cl + DIM_W'(1);
      if (col_q == COL_W'(1)) mask_d[2:0] = 3'b111;
      if (row_q == DIM_W'(1)) begin
        mask_d[0] = 1'b1;
        mask_d[3] = 1'b1;
        mask_d[6] = 1'b1;
      end
      if (row_q >= h_cl) begin
        mask_d[2] = 1'b1;
        mask_d[5] = 1'b1;
        mask_d[8] = 1'b1;
      end
    end
    last_d = emit_d && (pos_q == whm1_q);

    col_inc = {{(DIM_W-COL_W){1'b0}}, col_q} + DIM_W'(1);
    wrap    = col_inc >= w_cl;
    row_inc = wrap ? row_q + DIM_W'(1) : row_q;
    row_cap = h_cl + DIM_W'(1);

    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    if (cfg_we) begin
      col_d = '0;
      row_d = '0;
      pos_d = '0;
    end else if (acc) begin
      if (last_d) begin
        col_d = '0;
        row_d = '0;
        pos_d = '0;
      end else begin
        col_d = wrap ? '0 : col_inc[COL_W-1:0];
        row_d = (row_inc > row_cap) ? row_cap : row_inc;
        pos_d = emit_d ? pos_q + POS_W'(1) : pos_q;
      end
    end
  end

  // configuration registers; the frame size product is formed at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MAX_W_DIM;
      height_q <= MAX_H_DIM;
      whm1_q   <= POS_W'(MAX_WIDTH * MAX_HEIGHT - 1);
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[DIM_W-1:0];
        whm1_q  <= POS_W'(PROD_W'(wr_cl) * PROD_W'(h_cl) - PROD_W'(1));
      end else begin
        height_q <= pwdata[DIM_W-1:0];
        whm1_q   <= POS_W'(PROD_W'(w_cl) * PROD_W'(wr_cl) - PROD_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pos_q <= pos_d;
      if (cfg_we) begin
        for (int k = 0; k < 9; k++) win_q[k] <= '0;
      end else if (acc) begin
        for (int k = 0; k < 6; k++) win_q[k] <= win_q[k+3];
        win_q[6] <= up_rd_q;
        win_q[7] <= mid_rd_q;
        win_q[8] <= pix;
      end
    end
  end

  // Read ahead at the next column; forward the write when it hits the same entry.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_mem[col_q]  <= mid_rd_q;
      mid_mem[col_q] <= pix;
    end
    if (acc && col_d == col_q) begin
      up_rd_q  <= mid_rd_q;
      mid_rd_q <= pix;
    end else begin
      up_rd_q  <= up_mem[col_d];
      mid_rd_q <= mid_mem[col_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= emit_d;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mask_q    <= mask_d;
      s1_last_q <= last_d;
    end
  end

  // weighted sum 1/4/20, then floor(sum/40) = floor((sum >> 3) / 5)
  always_comb begin
    logic [7:0]  t [9];
    logic [13:0] sum;
    logic [10:0] x;
    logic [24:0] prod;
    for (int ch = 0; ch < 4; ch++) begin
      for (int k = 0; k < 9; k++) begin
        t[k] = mask_q[k] ? 8'd0 : win_q[k][8*ch +: 8];
      end
      sum = 14'(t[0]) + 14'(t[2]) + 14'(t[6]) + 14'(t[8])
          + ((14'(t[1]) + 14'(t[3]) + 14'(t[5]) + 14'(t[7])) << 2)
          + 14'(t[4]) * 14'd20;
      x = sum[13:3];
      prod = 25'(x) * 25'(DIV5_MUL);
      blur_ch[ch] = prod[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.out_red       <= blur_ch[0];
      out_q.out_green     <= blur_ch[1];
      out_q.out_blue      <= blur_ch[2];
      out_q.out_alpha     <= blur_ch[3];
      out_q.last_of_frame <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // hold the window stage while the input is stalled
  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("window stage lost while input stalled");

  a_stage_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("window stage advanced without filling output");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last_d && !cfg_we) |=> (col_q == '0 && row_q == '0 && pos_q == '0))
    else $error("frame counters not cleared after last pixel");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(DIM_W-COL_W){1'b0}}, col_q} < w_cl)
    else $error("column counter beyond image width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_cl + DIM_W'(1))
    else $error("row counter beyond frame");

endmodule
